// ===== rtl/core/rgb_to_hsv_lamp_scaler_top_macros.svh =====
// assertion macros used by the port-level checker
`ifndef RGB_TO_HSV_LAMP_SCALER_TOP_MACROS_SVH
`define RGB_TO_HSV_LAMP_SCALER_TOP_MACROS_SVH

// same-cycle implication, reset gated
`define RHLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset gated
`define RHLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rhls_pkg.sv =====
// shared types and constants for the rgb to hsv lamp scaler
package rhls_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned HUE_W       = 16;
  localparam int unsigned LVL_W       = 8;
  localparam int unsigned HDIV_W      = 11;  // holds 6 * chroma
  localparam int unsigned HUE_STEP    = 4;   // hue quotient bits per divider stage
  localparam int unsigned SAT_STEP    = 2;   // saturation quotient bits per divider stage
  localparam int unsigned DIV_STAGES  = HUE_W / HUE_STEP;
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned PIPE_LAT    = FRONT_STAGES + DIV_STAGES + 1;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
  } rhls_in_t;

  typedef struct packed {
    logic              light_on;
    logic [HUE_W-1:0]  hue_out;
    logic [LVL_W-1:0]  sat_out;
    logic [LVL_W-1:0]  bri_out;
  } rhls_out_t;

  // one beat inside the divider pipeline
  typedef struct packed {
    logic              light_on;
    logic              grey;
    logic [LVL_W-1:0]  bri;
    logic [HDIV_W-1:0] hrem;
    logic [HUE_W-1:0]  hacc;
    logic [HDIV_W-1:0] hdiv;
    logic [CHAN_W-1:0] srem;
    logic [LVL_W-1:0]  sacc;
    logic [CHAN_W-1:0] sdiv;
  } rhls_div_t;

endpackage

// ===== rtl/core/rhls_front.sv =====
// front stages: max/min and sector, hue numerator, divider setup
module rhls_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  rhls_pkg::rhls_in_t  in_pix,
  output logic                out_vld,
  output rhls_pkg::rhls_div_t out_beat
);
  import rhls_pkg::*;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sect_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] hi;
    logic [CHAN_W-1:0] lo;
    sect_t             sect;
    logic              light_on;
    logic [LVL_W-1:0]  bri;
  } stg_a_t;

  typedef struct packed {
    logic [HDIV_W-1:0] num;
    logic [HDIV_W-1:0] div6;
    logic [CHAN_W-1:0] chroma;
    logic [CHAN_W-1:0] hi;
    logic              grey;
    logic              light_on;
    logic [LVL_W-1:0]  bri;
  } stg_b_t;

  logic      a_vld_r, b_vld_r, c_vld_r;
  stg_a_t    a_r, a_nxt;
  stg_b_t    b_r, b_nxt;
  rhls_div_t c_r, c_nxt;

  // stage a: extremes and winning channel, ties go to red then green
  always_comb begin
    logic [CHAN_W-1:0] rg_max, rg_min;
    rg_max = (in_pix.red_in >= in_pix.green_in) ? in_pix.red_in : in_pix.green_in;
    rg_min = (in_pix.red_in <= in_pix.green_in) ? in_pix.red_in : in_pix.green_in;
    a_nxt.red   = in_pix.red_in;
    a_nxt.green = in_pix.green_in;
    a_nxt.blue  = in_pix.blue_in;
    a_nxt.hi    = (rg_max >= in_pix.blue_in) ? rg_max : in_pix.blue_in;
    a_nxt.lo    = (rg_min <= in_pix.blue_in) ? rg_min : in_pix.blue_in;
    if (in_pix.red_in >= in_pix.green_in && in_pix.red_in >= in_pix.blue_in) begin
      a_nxt.sect = SECT_RED;
    end else if (in_pix.green_in >= in_pix.blue_in) begin
      a_nxt.sect = SECT_GREEN;
    end else begin
      a_nxt.sect = SECT_BLUE;
    end
    a_nxt.light_on = (in_pix.alpha_in != '0);
    // alpha*254/255 floors to alpha-1 for any nonzero alpha
    a_nxt.bri = (in_pix.alpha_in == '0) ? '0 : in_pix.alpha_in - LVL_W'(1);
  end

  // stage b: chroma and wrapped sector numerator in [0, 6c)
  always_comb begin
    logic [HDIV_W-1:0] c_w, r_w, g_w, b_w;
    c_w = HDIV_W'(a_r.hi - a_r.lo);
    r_w = HDIV_W'(a_r.red);
    g_w = HDIV_W'(a_r.green);
    b_w = HDIV_W'(a_r.blue);
    b_nxt.chroma   = a_r.hi - a_r.lo;
    b_nxt.div6     = (c_w << 2) + (c_w << 1);
    b_nxt.hi       = a_r.hi;
    b_nxt.grey     = (a_r.hi == a_r.lo);
    b_nxt.light_on = a_r.light_on;
    b_nxt.bri      = a_r.bri;
    case (a_r.sect)
      SECT_RED: begin
        if (a_r.green >= a_r.blue) begin
          b_nxt.num = g_w - b_w;
        end else begin
          b_nxt.num = (c_w << 2) + (c_w << 1) + g_w - b_w;
        end
      end
      SECT_GREEN: b_nxt.num = b_w + (c_w << 1) - r_w;
      SECT_BLUE:  b_nxt.num = r_w + (c_w << 2) - g_w;
      default:    b_nxt.num = '0;
    endcase
  end

  // stage c: dividends num*65535 and c*254 as shift-subtract, split for long division
  always_comb begin
    logic [HDIV_W+HUE_W-1:0] hdvd;
    logic [CHAN_W+LVL_W-1:0] sdvd;
    hdvd = ((HDIV_W+HUE_W)'(b_r.num) << HUE_W) - (HDIV_W+HUE_W)'(b_r.num);
    sdvd = ((CHAN_W+LVL_W)'(b_r.chroma) << LVL_W) - ((CHAN_W+LVL_W)'(b_r.chroma) << 1);
    c_nxt.light_on = b_r.light_on;
    c_nxt.grey     = b_r.grey;
    c_nxt.bri      = b_r.bri;
    c_nxt.hrem     = hdvd[HDIV_W+HUE_W-1:HUE_W];
    c_nxt.hacc     = hdvd[HUE_W-1:0];
    c_nxt.hdiv     = b_r.div6;
    c_nxt.srem     = sdvd[CHAN_W+LVL_W-1:LVL_W];
    c_nxt.sacc     = sdvd[LVL_W-1:0];
    c_nxt.sdiv     = b_r.hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
  end

  assign out_vld  = c_vld_r;
  assign out_beat = c_r;

endmodule

// ===== rtl/core/rhls_div_stage.sv =====
// one restoring-divider stage: HUE_STEP hue and SAT_STEP saturation quotient bits
module rhls_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  rhls_pkg::rhls_div_t in_beat,
  output logic                out_vld,
  output rhls_pkg::rhls_div_t out_beat
);
  import rhls_pkg::*;

  logic      vld_r;
  rhls_div_t beat_r, beat_nxt;

  always_comb begin
    logic [HDIV_W:0] htry;
    logic [CHAN_W:0] stry;
    beat_nxt = in_beat;
    // quotient bits shift in at the bottom as dividend bits leave the top
    for (int i = 0; i < HUE_STEP; i++) begin
      htry          = {beat_nxt.hrem, beat_nxt.hacc[HUE_W-1]};
      beat_nxt.hacc = {beat_nxt.hacc[HUE_W-2:0], 1'b0};
      if (htry >= {1'b0, beat_nxt.hdiv}) begin
        htry             = htry - {1'b0, beat_nxt.hdiv};
        beat_nxt.hacc[0] = 1'b1;
      end
      beat_nxt.hrem = htry[HDIV_W-1:0];
    end
    for (int j = 0; j < SAT_STEP; j++) begin
      stry          = {beat_nxt.srem, beat_nxt.sacc[LVL_W-1]};
      beat_nxt.sacc = {beat_nxt.sacc[LVL_W-2:0], 1'b0};
      if (stry >= {1'b0, beat_nxt.sdiv}) begin
        stry             = stry - {1'b0, beat_nxt.sdiv};
        beat_nxt.sacc[0] = 1'b1;
      end
      beat_nxt.srem = stry[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_vld  = vld_r;
  assign out_beat = beat_r;

endmodule

// ===== rtl/core/rgb_to_hsv_lamp_scaler_top.sv =====
// top level of the rgb to hsv lamp scaler pipeline
//
// Converts one rgba pixel per beat into lamp settings: light_on, hue (full
// turn = 65535), saturation and brightness (0..254, brightness from alpha).
// Input: drive in_data and raise start; the beat is taken at a clock edge
// with start high and busy low. busy stays low, so a pixel can be given in
// every cycle.
// Output: out_valid is high for exactly one cycle with out_res; the result
// is taken at the edge that ends that cycle. The receiver cannot stall.
// Pipeline: a taken pixel passes three front stages, four divider stages
// and one output register. Throughput is one pixel per cycle; the depth
// is set by the hue long division, four quotient bits per stage.
// Reset (synchronous, rst_n low) clears all valid bits; beats in flight
// are dropped and no result appears until new pixels enter.
// Alpha zero gives an all-zero result; grey pixels give hue and sat zero.
module rgb_to_hsv_lamp_scaler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rhls_pkg::rhls_in_t  in_data,
  output logic                out_valid,
  output rhls_pkg::rhls_out_t out_res
);
  import rhls_pkg::*;

  logic      stg_vld [DIV_STAGES+1];
  rhls_div_t stg_beat [DIV_STAGES+1];

  logic      out_valid_r;
  rhls_out_t out_res_r, out_res_nxt;
  rhls_div_t last_beat;

  assign busy = 1'b0;

  rhls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_pix   (in_data),
    .out_vld  (stg_vld[0]),
    .out_beat (stg_beat[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rhls_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (stg_vld[s]),
      .in_beat  (stg_beat[s]),
      .out_vld  (stg_vld[s+1]),
      .out_beat (stg_beat[s+1])
    );
  end

  assign last_beat = stg_beat[DIV_STAGES];

  // lamp off clears everything, grey clears hue and saturation
  always_comb begin
    out_res_nxt.light_on = last_beat.light_on;
    out_res_nxt.bri_out  = last_beat.light_on ? last_beat.bri : '0;
    if (!last_beat.light_on || last_beat.grey) begin
      out_res_nxt.hue_out = '0;
      out_res_nxt.sat_out = '0;
    end else begin
      out_res_nxt.hue_out = last_beat.hacc;
      out_res_nxt.sat_out = last_beat.sacc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/core/rhls_checker.sv =====
// port-level checks for the lamp scaler, bound to the top level
`include "rgb_to_hsv_lamp_scaler_top_macros.svh"

module rhls_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input rhls_pkg::rhls_in_t  in_data,
  input logic                out_valid,
  input rhls_pkg::rhls_out_t out_res
);
  import rhls_pkg::*;

  // every result traces back to a beat taken a fixed depth earlier
  `RHLS_ASSERT_NOW(a_res_has_src, clk, rst_n, out_valid, $past(start && !busy, PIPE_LAT), "result without matching input beat")

  // lamp state follows the alpha of that beat
  `RHLS_ASSERT_NOW(a_light_alpha, clk, rst_n, out_valid, out_res.light_on == ($past(in_data.alpha_in, PIPE_LAT) != '0), "light_on does not follow alpha")

  // an off lamp carries no colour or level
  `RHLS_ASSERT_NOW(a_off_zero, clk, rst_n, out_valid && !out_res.light_on, out_res.hue_out == '0 && out_res.sat_out == '0 && out_res.bri_out == '0, "lamp off with nonzero fields")

  // levels stay within their scale
  `RHLS_ASSERT_NEXT(a_level_range, clk, rst_n, 1'b1, !out_valid || (out_res.sat_out <= 8'd254 && out_res.bri_out <= 8'd254), "level above 254")

endmodule

bind rgb_to_hsv_lamp_scaler_top rhls_checker u_rhls_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench for the rgb to hsv lamp scaler: directed and random pixels
`timescale 1ns / 1ps

module tb_top;
  import rhls_pkg::*;

  localparam int unsigned HUE_FULL   = 65535;
  localparam int unsigned LEVEL_TOP  = 254;
  localparam int unsigned CHAN_TOP   = 255;
  localparam int unsigned GAP_MAX    = 16;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned RAND_PIXELS = 400;
  localparam int unsigned BLOCK_LEN  = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  rhls_in_t  in_data = '0;
  logic      out_valid;
  rhls_out_t out_res;

  rhls_out_t   pending_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          back_to_back = 1'b0;

  rgb_to_hsv_lamp_scaler_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always #10 clk = ~clk;

  // lamp setting a pixel should give
  function automatic rhls_out_t lamp_setting(input rhls_in_t px);
    rhls_out_t   res;
    int unsigned r, g, b, a, hi, lo, chroma, sector;
    res = '0;
    r = 32'(px.red_in);
    g = 32'(px.green_in);
    b = 32'(px.blue_in);
    a = 32'(px.alpha_in);
    if (a == 0) return res;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    chroma = hi - lo;
    res.light_on = 1'b1;
    if (chroma != 0) begin
      // ties go to red, then green
      if (hi == r) begin
        sector = (g >= b) ? g - b : 6 * chroma - (b - g);
      end else if (hi == g) begin
        sector = b + 2 * chroma - r;
      end else begin
        sector = r + 4 * chroma - g;
      end
      res.hue_out = HUE_W'((sector * HUE_FULL) / (6 * chroma));
      res.sat_out = LVL_W'((chroma * LEVEL_TOP) / hi);
    end
    res.bri_out = LVL_W'((a * LEVEL_TOP) / CHAN_TOP);
    return res;
  endfunction

  function automatic rhls_in_t pixel(input int unsigned r, g, b, a);
    rhls_in_t px;
    px.red_in   = CHAN_W'(r);
    px.green_in = CHAN_W'(g);
    px.blue_in  = CHAN_W'(b);
    px.alpha_in = CHAN_W'(a);
    return px;
  endfunction

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_pixel(input rhls_in_t px);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
    pending_q.push_back(lamp_setting(px));
  endtask

  task automatic report_field(input string name, input int unsigned want, got);
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    mismatch_cnt++;
  endtask

  // every beat on the result side is checked against the oldest expectation
  always @(posedge clk) begin
    rhls_out_t want;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        $display("%0t: out_valid expected 0 or 1 got %b", $time, out_valid);
        mismatch_cnt++;
      end else if (out_valid) begin
        if (pending_q.size() == 0) begin
          $display("%0t: result expected none got %h", $time, out_res);
          mismatch_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (out_res.light_on !== want.light_on)
            report_field("light_on", 32'(want.light_on), 32'(out_res.light_on));
          if (out_res.hue_out !== want.hue_out)
            report_field("hue_out", 32'(want.hue_out), 32'(out_res.hue_out));
          if (out_res.sat_out !== want.sat_out)
            report_field("sat_out", 32'(want.sat_out), 32'(out_res.sat_out));
          if (out_res.bri_out !== want.bri_out)
            report_field("bri_out", 32'(want.bri_out), 32'(out_res.bri_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_extremes;
    send_pixel(pixel(0, 0, 0, 0));
    send_pixel(pixel(255, 255, 255, 255));
    send_pixel(pixel(0, 0, 0, 255));
    send_pixel(pixel(255, 0, 0, 255));
    send_pixel(pixel(0, 255, 0, 1));
    send_pixel(pixel(0, 0, 255, 254));
    send_pixel(pixel(1, 0, 0, 128));
    send_pixel(pixel(255, 254, 0, 200));
  endtask

  task automatic test_grey_and_lamp_off;
    send_pixel(pixel(128, 128, 128, 100));
    send_pixel(pixel(1, 1, 1, 1));
    send_pixel(pixel(255, 0, 0, 0));
    send_pixel(pixel(17, 200, 93, 0));
    send_pixel(pixel(0, 0, 0, 0));
  endtask

  task automatic test_sector_ties;
    send_pixel(pixel(255, 255, 0, 255));   // red and green tie
    send_pixel(pixel(0, 255, 255, 255));   // green and blue tie
    send_pixel(pixel(255, 0, 255, 255));   // red and blue tie
    send_pixel(pixel(255, 0, 10, 77));     // red max, green below blue wraps
    send_pixel(pixel(255, 0, 254, 77));
    send_pixel(pixel(10, 255, 0, 33));
    send_pixel(pixel(0, 10, 255, 33));
    send_pixel(pixel(200, 0, 255, 33));
  endtask

  task automatic test_random_pixels;
    rhls_in_t    px;
    int unsigned v;
    for (int unsigned n = 0; n < RAND_PIXELS; n++) begin
      // mix gap-free stretches with gappy ones, chosen at random per block
      if (n % BLOCK_LEN == 0) back_to_back = ($urandom_range(0, 2) == 0);
      px = rhls_in_t'($urandom);
      case ($urandom_range(0, 7))
        0: begin
          v = $urandom_range(0, CHAN_TOP);
          px = pixel(v, v, v, 32'(px.alpha_in));
        end
        1: px.alpha_in = '0;
        2: px.green_in = px.red_in;
        3: px.blue_in = px.green_in;
        4: px.blue_in = px.red_in;
        default: ;
      endcase
      send_pixel(px);
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_grey_and_lamp_off();
    test_sector_ties();
    test_random_pixels();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
